// File: rtl/core/rsb_pkg.sv
// ----------------------------------------------------------------------------
// rsb_pkg: shared types and constants for the radix string converter
// Character codes, configuration register indexes and the digit decoder.
// ----------------------------------------------------------------------------
package rsb_pkg;

	localparam int RADIX_W      = 6;
	localparam int WIDTH_W      = 7;
	localparam int CFG_DATA_W   = 7;
	localparam int CFG_INDEX_W  = 1;
	localparam int DIGIT_W      = 6;
	localparam int MAX_WIDTH_DEFAULT = 64;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;

	localparam logic [CFG_INDEX_W-1:0] REG_RADIX        = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_RESULT_WIDTH = 1'b1;

	localparam logic [7:0] CHAR_0       = 8'h30;
	localparam logic [7:0] CHAR_9       = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] LETTER_BASE  = 8'd10;

	typedef struct packed {
		logic               ok;
		logic [DIGIT_W-1:0] val;
	} digit_t;

	typedef struct packed {
		logic fire;
		logic last;
	} step_t;

	function automatic digit_t decode_digit(input logic [7:0] c);
		digit_t     d;
		logic [7:0] t;
		d.ok = 1'b0;
		t    = 8'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			d.ok = 1'b1;
			t    = c - CHAR_0;
		end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			d.ok = 1'b1;
			t    = c - CHAR_UPPER_A + LETTER_BASE;
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			d.ok = 1'b1;
			t    = c - CHAR_LOWER_A + LETTER_BASE;
		end
		d.val = t[DIGIT_W-1:0];
		return d;
	endfunction

endpackage

// File: rtl/core/rsb_accum.sv
// ----------------------------------------------------------------------------
// rsb_accum: digit accumulator
// Holds the running value and sticky flags; computes acc * radix + digit.
// ----------------------------------------------------------------------------
module rsb_accum #(
	parameter int MAX_WIDTH = rsb_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rsb_pkg::step_t               step,
	input  logic [7:0]                   char_code,
	input  logic [rsb_pkg::RADIX_W-1:0]  radix,
	output logic [MAX_WIDTH-1:0]         acc_next,
	output logic                         ovf_next,
	output logic                         inv_next
);

	localparam int PW = MAX_WIDTH + rsb_pkg::RADIX_W + 1;

	logic [MAX_WIDTH-1:0] acc_q;
	logic                 ovf_q;
	logic                 inv_q;
	rsb_pkg::digit_t      dig;
	logic [PW-1:0]        sum;

	assign dig = rsb_pkg::decode_digit(char_code);
	assign sum = PW'(acc_q) * PW'(radix) + PW'(dig.val);

	always_comb begin
		if (dig.ok) begin
			acc_next = sum[MAX_WIDTH-1:0];
			ovf_next = ovf_q | (|sum[PW-1:MAX_WIDTH]);
			inv_next = inv_q;
		end else begin
			acc_next = acc_q;
			ovf_next = ovf_q;
			inv_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
			inv_q <= 1'b0;
		end else if (step.fire) begin
			if (step.last) begin
				acc_q <= '0;
				ovf_q <= 1'b0;
				inv_q <= 1'b0;
			end else begin
				acc_q <= acc_next;
				ovf_q <= ovf_next;
				inv_q <= inv_next;
			end
		end
	end

`ifndef SYNTH
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step.fire && step.last |=> acc_q == '0 && !ovf_q && !inv_q)
		else $error("accumulator not cleared after last character");
	a_invalid_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		step.fire && !step.last && !dig.ok |=> inv_q)
		else $error("invalid flag not set by non-digit");
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step.fire |=> $stable(acc_q) && $stable(ovf_q) && $stable(inv_q))
		else $error("accumulator changed without a character");
`endif

endmodule

// File: rtl/core/radix_string_to_binary.sv
// ----------------------------------------------------------------------------
// radix_string_to_binary: ASCII radix text to binary integer
// Accumulates digit characters and returns the value, negated on request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one character per request,
//   most significant first, with last_char on the final one and negative
//   sampled with it. Non-last characters produce no output.
//   Output channel (out_valid / out_stall) carries one result per number:
//   value masked to result_width, invalid_digit and overflow.
//   Configuration channel (cfg_valid / cfg_ready, always ready) writes
//   radix (index 0) and result_width (index 1); write only while idle.
//   Throughput: one character per cycle while in_stall is low, set by the
//   single multiply-add acc * radix + digit that closes the accumulator loop.
//   Result path: a last character passes the input register, accumulate
//   and negate steps before its result is registered on the output.
//   Reset clears the pipeline, the accumulator and flags, and sets radix
//   to 10 and result_width to 64.
//   A stalled output holds its result; characters are still taken until a
//   last character finds the result path full, then in_stall rises.
// ----------------------------------------------------------------------------
module radix_string_to_binary #(
	parameter int MAX_WIDTH = rsb_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      char_code,
	input  logic                            last_char,
	input  logic                            negative,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [MAX_WIDTH-1:0]            value,
	output logic                            invalid_digit,
	output logic                            overflow,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rsb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [rsb_pkg::RADIX_W-1:0] radix_q;
	logic [rsb_pkg::WIDTH_W-1:0] width_q;
	logic [rsb_pkg::WIDTH_W-1:0] width_eff;
	logic [MAX_WIDTH-1:0]        wmask;

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 last_s1;
	logic                 neg_s1;

	logic                 valid_s2;
	logic [MAX_WIDTH-1:0] val_s2;
	logic                 neg_s2;
	logic                 inv_s2;
	logic                 ovf_s2;

	logic                 out_free;
	logic                 s2_free;
	logic                 s1_adv;
	logic                 s2_adv;
	rsb_pkg::step_t       step;
	logic [MAX_WIDTH-1:0] acc_next;
	logic                 ovf_next;
	logic                 inv_next;
	logic [MAX_WIDTH-1:0] neg_val;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rsb_pkg::RADIX_RESET;
			width_q <= rsb_pkg::WIDTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rsb_pkg::REG_RADIX:        radix_q <= cfg_data[rsb_pkg::RADIX_W-1:0];
				rsb_pkg::REG_RESULT_WIDTH: width_q <= cfg_data[rsb_pkg::WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			width_eff = rsb_pkg::WIDTH_W'(1);
		else if (width_q > rsb_pkg::WIDTH_W'(MAX_WIDTH))
			width_eff = rsb_pkg::WIDTH_W'(MAX_WIDTH);
		else
			width_eff = width_q;
		for (int i = 0; i < MAX_WIDTH; i++)
			wmask[i] = rsb_pkg::WIDTH_W'(i) < width_eff;
	end

	assign out_free = !out_valid || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_adv   = valid_s1 && (!last_s1 || s2_free);
	assign s2_adv   = valid_s2 && out_free;
	assign in_stall = valid_s1 && last_s1 && !s2_free;

	assign step.fire = s1_adv;
	assign step.last = last_s1;

	rsb_accum #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_code (char_s1),
		.radix     (radix_q),
		.acc_next  (acc_next),
		.ovf_next  (ovf_next),
		.inv_next  (inv_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
			neg_s1  <= negative;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_adv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			val_s2 <= acc_next & wmask;
			neg_s2 <= neg_s1;
			inv_s2 <= inv_next;
			ovf_s2 <= ovf_next | (|(acc_next & ~wmask));
		end
	end

	assign neg_val = (~val_s2 + MAX_WIDTH'(1)) & wmask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			if (inv_s2) begin
				value    <= '0;
				overflow <= 1'b0;
			end else begin
				value    <= neg_s2 ? neg_val : val_s2;
				overflow <= ovf_s2;
			end
			invalid_digit <= inv_s2;
		end
	end

`ifndef SYNTH
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && valid_s2)
		else $error("input stalled without a pending last character");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalid_digit |-> value == '0 && !overflow)
		else $error("invalid number gave nonzero value or overflow");
	a_upper_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value & ~wmask) == '0)
		else $error("result bits set above configured width");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for radix_string_to_binary
// Feeds ASCII number text through the character channel, computes each number
// in its own accumulator model, and compares every returned value and flag.
// Directed cases cover digit and letter limits, invalid characters, overflow
// and degenerate settings; random numbers run under four idling schemes.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [63:0] value;
		logic        invalid_digit;
		logic        overflow;
	} conversion_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [7:0]                      char_code;
	logic                            last_char;
	logic                            negative;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [63:0]                     value;
	logic                            invalid_digit;
	logic                            overflow;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [rsb_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [rsb_pkg::CFG_DATA_W-1:0]  cfg_data;

	logic [rsb_pkg::RADIX_W-1:0]     model_radix;
	logic [rsb_pkg::WIDTH_W-1:0]     model_width;
	logic [63:0]                     num_acc;
	logic                            num_overflow;
	logic                            num_invalid;
	conversion_t                     converted_q[$];
	conversion_t                     want_result;

	int                              tx_idle_pct = 0;
	int                              rx_stall_pct = 0;
	int unsigned                     mismatch_count = 0;
	int unsigned                     cycle_count = 0;

	radix_string_to_binary dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.last_char    (last_char),
		.negative     (negative),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.invalid_digit(invalid_digit),
		.overflow     (overflow),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected %h, got %h", $time, what, want, got);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (converted_q.size() == 0) begin
				note_mismatch("result with no number pending", '0, value);
			end else begin
				want_result = converted_q.pop_front();
				if (value !== want_result.value)
					note_mismatch("value", want_result.value, value);
				if (invalid_digit !== want_result.invalid_digit)
					note_mismatch("invalid_digit", 64'(want_result.invalid_digit),
						64'(invalid_digit));
				if (overflow !== want_result.overflow)
					note_mismatch("overflow", 64'(want_result.overflow), 64'(overflow));
			end
		end
	end

	task automatic accumulate_char(input logic [7:0] c, input logic last, input logic neg);
		logic [5:0]   digit;
		logic         is_digit;
		logic [71:0]  wide;
		logic [6:0]   eff_width;
		logic [63:0]  mask;
		conversion_t  res;
		is_digit = 1'b1;
		digit    = '0;
		if (c >= rsb_pkg::CHAR_0 && c <= rsb_pkg::CHAR_9)
			digit = 6'(c - rsb_pkg::CHAR_0);
		else if (c >= rsb_pkg::CHAR_UPPER_A && c <= rsb_pkg::CHAR_UPPER_Z)
			digit = 6'(c - rsb_pkg::CHAR_UPPER_A + rsb_pkg::LETTER_BASE);
		else if (c >= rsb_pkg::CHAR_LOWER_A && c <= rsb_pkg::CHAR_LOWER_Z)
			digit = 6'(c - rsb_pkg::CHAR_LOWER_A + rsb_pkg::LETTER_BASE);
		else
			is_digit = 1'b0;
		if (!is_digit) begin
			num_invalid = 1'b1;
		end else begin
			wide = 72'(num_acc) * 72'(model_radix) + 72'(digit);
			if (wide[71:64] != 8'd0)
				num_overflow = 1'b1;
			num_acc = wide[63:0];
		end
		if (last) begin
			if (model_width == 7'd0)
				eff_width = 7'd1;
			else if (model_width > 7'd64)
				eff_width = 7'd64;
			else
				eff_width = model_width;
			mask = (eff_width == 7'd64) ? '1 : (64'd1 << eff_width) - 64'd1;
			res.overflow      = num_overflow || ((num_acc & ~mask) != 64'd0);
			res.value         = num_acc & mask;
			res.invalid_digit = num_invalid;
			if (neg)
				res.value = (~res.value + 64'd1) & mask;
			if (num_invalid) begin
				res.value    = '0;
				res.overflow = 1'b0;
			end
			converted_q.push_back(res);
			num_acc      = '0;
			num_overflow = 1'b0;
			num_invalid  = 1'b0;
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic last, input logic neg);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		last_char <= last;
		negative  <= neg;
		do @(posedge clk); while (in_stall);
		accumulate_char(c, last, neg);
		@(negedge clk);
	endtask

	// drop valid, wait for every result, then let the pipeline settle
	task automatic finish_traffic();
		in_valid <= 1'b0;
		while (converted_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [rsb_pkg::CFG_INDEX_W-1:0] idx,
			input logic [rsb_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rsb_pkg::REG_RADIX:        model_radix = data[rsb_pkg::RADIX_W-1:0];
			rsb_pkg::REG_RESULT_WIDTH: model_width = data[rsb_pkg::WIDTH_W-1:0];
			default:                   ;
		endcase
		@(negedge clk);
	endtask

	task automatic program_format(input logic [rsb_pkg::CFG_DATA_W-1:0] radix_data,
			input logic [rsb_pkg::CFG_DATA_W-1:0] width_data);
		write_reg(rsb_pkg::REG_RADIX, radix_data);
		write_reg(rsb_pkg::REG_RESULT_WIDTH, width_data);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] random_digit();
		int unsigned d;
		if (model_radix >= 6'd2 && model_radix <= 6'd36 && $urandom_range(9) != 0)
			d = $urandom_range(model_radix - 1);
		else
			d = $urandom_range(35);
		if (d < 10)
			return rsb_pkg::CHAR_0 + 8'(d);
		if ($urandom_range(1) != 0)
			return rsb_pkg::CHAR_UPPER_A + 8'(d - 10);
		return rsb_pkg::CHAR_LOWER_A + 8'(d - 10);
	endfunction

	task automatic send_number(input bit noisy, output int unsigned len);
		logic [7:0]  c;
		int unsigned i;
		if ($urandom_range(7) == 0)
			len = $urandom_range(10, 24);
		else
			len = $urandom_range(1, 6);
		for (i = 0; i < len; i++) begin
			if (noisy && $urandom_range(3) == 0)
				c = 8'($urandom_range(255));
			else
				c = random_digit();
			send_char(c, i == len - 1, 1'($urandom_range(1)));
		end
	endtask

	function automatic logic [rsb_pkg::CFG_DATA_W-1:0] pick_radix(input int k);
		logic [rsb_pkg::RADIX_W-1:0] r;
		case (k)
			0: r = 6'd2;
			1: r = 6'd36;
			default: begin
				case ($urandom_range(4))
					0:       r = 6'd10;
					1:       r = 6'd16;
					2:       r = 6'($urandom_range(63));
					default: r = 6'($urandom_range(2, 36));
				endcase
			end
		endcase
		return {1'($urandom_range(1)), r};
	endfunction

	function automatic logic [rsb_pkg::CFG_DATA_W-1:0] pick_width(input int k);
		case (k)
			0: return 7'd1;
			1: return 7'd64;
			2: return 7'd127;
			default: begin
				case ($urandom_range(4))
					0:       return 7'($urandom_range(127));
					1:       return 7'd8;
					2:       return 7'd32;
					default: return 7'($urandom_range(1, 64));
				endcase
			end
		endcase
	endfunction

	task automatic test_reset_config();
		logic [7:0] bad_chars[8];
		int         i;
		bad_chars = '{8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80, 8'hFF};
		send_char(rsb_pkg::CHAR_9, 1'b1, 1'b0);
		send_char(rsb_pkg::CHAR_0, 1'b1, 1'b1);
		for (i = 0; i < 8; i++)
			send_char(bad_chars[i], i == 7, 1'b1);
		finish_traffic();
	endtask

	task automatic test_letter_digits();
		program_format(7'd36, 7'd8);
		send_char(rsb_pkg::CHAR_UPPER_A, 1'b0, 1'b0);
		send_char(rsb_pkg::CHAR_LOWER_A, 1'b1, 1'b0);
		send_char(rsb_pkg::CHAR_UPPER_Z, 1'b0, 1'b0);
		send_char(rsb_pkg::CHAR_LOWER_Z, 1'b1, 1'b1);
		finish_traffic();
	endtask

	task automatic test_accumulator_overflow();
		int i;
		program_format(7'h7F, 7'h7F);
		for (i = 0; i < 11; i++)
			send_char(rsb_pkg::CHAR_LOWER_Z, i == 10, 1'b0);
		finish_traffic();
	endtask

	task automatic test_degenerate_config();
		program_format(7'd0, 7'd0);
		send_char(rsb_pkg::CHAR_9, 1'b1, 1'b1);
		finish_traffic();
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct);
		int unsigned sent;
		int unsigned n;
		int          k;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (k = 0; k < 8; k++) begin
			program_format(pick_radix(k), pick_width(k));
			sent = 0;
			while (sent < 50) begin
				send_number($urandom_range(4) == 0, n);
				sent += n;
			end
			finish_traffic();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		char_code    = '0;
		last_char    = 1'b0;
		negative     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = rsb_pkg::REG_RADIX;
		cfg_data     = '0;
		model_radix  = rsb_pkg::RADIX_RESET;
		model_width  = rsb_pkg::WIDTH_RESET;
		num_acc      = '0;
		num_overflow = 1'b0;
		num_invalid  = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_config();
		test_letter_digits();
		test_accumulator_overflow();
		test_degenerate_config();
		test_random_traffic(0, 0);
		test_random_traffic(72, 0);
		test_random_traffic(0, 72);
		test_random_traffic(12, 12);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/rsb_pkg.sv
rtl/core/rsb_accum.sv
rtl/core/radix_string_to_binary.sv
tb/tb.sv
